### sv/scps_pkg.sv
// Shared constants, codes and types of the sliced column predicate scan.
package scps_pkg;

    // Sizes of the datapath.
    localparam int LANES         = 64;
    localparam int MAX_CODE_BITS = 32;
    localparam int ACTIVE_W      = 7;
    localparam int CW_W          = 6;
    localparam int PLANE_CNT_W   = 6;
    localparam int LIT_W         = 32;
    localparam int LIT_IDX_W     = $clog2(LIT_W);
    localparam int CMP_W         = 3;
    localparam int COMB_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Depth of the work queue between front and back, and of the result queue.
    localparam int WQ_DEPTH = 2;
    localparam int WQ_PTR_W = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARISON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_OP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LITERAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_OTHER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_WIDTH   = 3'd4;

    localparam logic [CW_W-1:0] CODE_WIDTH_RESET = 6'd32;

    // Comparator codes.
    localparam logic [CMP_W-1:0] CMP_LESS          = 3'd0;
    localparam logic [CMP_W-1:0] CMP_GREATER       = 3'd1;
    localparam logic [CMP_W-1:0] CMP_LESS_EQUAL    = 3'd2;
    localparam logic [CMP_W-1:0] CMP_GREATER_EQUAL = 3'd3;
    localparam logic [CMP_W-1:0] CMP_EQUAL         = 3'd4;
    localparam logic [CMP_W-1:0] CMP_NOT_EQUAL     = 3'd5;

    // Combine codes.
    localparam logic [COMB_W-1:0] COMB_SET = 2'd0;
    localparam logic [COMB_W-1:0] COMB_AND = 2'd1;
    localparam logic [COMB_W-1:0] COMB_OR  = 2'd2;

    // One classified plane on its way from the front to the back.
    typedef struct packed {
        logic [LANES-1:0]    col;
        logic [LANES-1:0]    opnd;
        logic [LANES-1:0]    prior;
        logic [ACTIVE_W-1:0] lanes;
        logic                is_first;
        logic                is_last;
        logic [CMP_W-1:0]    cmp;
        logic [COMB_W-1:0]   comb;
    } t_work;

    // Status of the work queue.
    typedef struct packed {
        logic [WQ_CNT_W-1:0] count;
        logic                full;
        logic                head_valid;
    } t_wq_stat;

endpackage

### sv/scps_front.sv
// Front part: configuration registers, plane counter and operand selection.
module scps_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  logic [scps_pkg::LANES-1:0]         i_column_plane,
    input  logic [scps_pkg::LANES-1:0]         i_other_plane,
    input  logic [scps_pkg::LANES-1:0]         i_prior_bits,
    input  logic [scps_pkg::ACTIVE_W-1:0]      i_active_lanes,
    output scps_pkg::t_work                    o_work
);
    import scps_pkg::*;

    logic [CMP_W-1:0]       r_comparison;
    logic [COMB_W-1:0]      r_combine_op;
    logic [LIT_W-1:0]       r_literal_value;
    logic                   r_use_other;
    logic [CW_W-1:0]        r_code_width;
    logic [PLANE_CNT_W-1:0] r_plane_cnt;
    logic [PLANE_CNT_W-1:0] n_plane_cnt;

    logic [CW_W-1:0]        planes;
    logic                   is_last;
    logic [CW_W-1:0]        bit_idx;
    logic                   lit_bit;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comparison    <= CMP_LESS;
            r_combine_op    <= COMB_SET;
            r_literal_value <= '0;
            r_use_other     <= 1'b0;
            r_code_width    <= CODE_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMPARISON: begin
                    r_comparison <= i_cfg_data[CMP_W-1:0];
                end
                CFG_COMBINE_OP: begin
                    r_combine_op <= i_cfg_data[COMB_W-1:0];
                end
                CFG_LITERAL: begin
                    r_literal_value <= i_cfg_data[LIT_W-1:0];
                end
                CFG_USE_OTHER: begin
                    r_use_other <= i_cfg_data[0];
                end
                CFG_CODE_WIDTH: begin
                    r_code_width <= i_cfg_data[CW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Planes per code: zero acts as one, wide settings saturate.
    always_comb begin
        if (r_code_width == '0) begin
            planes = CW_W'(1);
        end else if (r_code_width > CW_W'(MAX_CODE_BITS)) begin
            planes = CW_W'(MAX_CODE_BITS);
        end else begin
            planes = r_code_width;
        end
    end

    // A counter at or past the final plane closes the code, even after a width change.
    assign is_last = (r_plane_cnt >= (planes - CW_W'(1)));
    assign bit_idx = is_last ? '0 : (planes - CW_W'(1) - r_plane_cnt);
    assign lit_bit = r_literal_value[bit_idx[LIT_IDX_W-1:0]];

    // Classified plane for the back part.
    always_comb begin
        o_work.col      = i_column_plane;
        o_work.opnd     = r_use_other ? i_other_plane : {LANES{lit_bit}};
        o_work.prior    = i_prior_bits;
        o_work.lanes    = i_active_lanes;
        o_work.is_first = (r_plane_cnt == '0);
        o_work.is_last  = is_last;
        o_work.cmp      = r_comparison;
        o_work.comb     = r_combine_op;
    end

    // Plane counter advances on each accepted request.
    assign n_plane_cnt = is_last ? '0 : (r_plane_cnt + PLANE_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_cnt <= '0;
        end else if (i_accept) begin
            r_plane_cnt <= n_plane_cnt;
        end
    end

endmodule

### sv/scps_work_q.sv
// Short queue of classified planes between the front and the back.
module scps_work_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  scps_pkg::t_work    i_work,
    input  logic               i_deq,
    output scps_pkg::t_work    o_head,
    output scps_pkg::t_wq_stat o_stat
);
    import scps_pkg::*;

    t_work               r_mem [WQ_DEPTH];
    logic [WQ_PTR_W-1:0] r_wr_ptr;
    logic [WQ_PTR_W-1:0] r_rd_ptr;
    logic [WQ_CNT_W-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign do_push = i_push && (r_count != WQ_CNT_W'(WQ_DEPTH));
    assign do_pop  = i_deq && (r_count != '0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + WQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + WQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + WQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - WQ_CNT_W'(1);
            end
        end
    end

    assign o_head            = r_mem[r_rd_ptr];
    assign o_stat.count      = r_count;
    assign o_stat.full       = (r_count == WQ_CNT_W'(WQ_DEPTH));
    assign o_stat.head_valid = (r_count != '0);

endmodule

### sv/scps_back.sv
// Back part: per-lane mask refinement, comparator, combine, lane clear and result queue.
module scps_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scps_pkg::t_work              i_head,
    input  logic                         i_head_valid,
    output logic                         o_deq,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [scps_pkg::LANES-1:0]   o_result_bits
);
    import scps_pkg::*;

    logic [LANES-1:0]    r_less;
    logic [LANES-1:0]    r_greater;
    logic [LANES-1:0]    r_equal;
    logic [LANES-1:0]    r_held;
    logic [LANES-1:0]    n_less;
    logic [LANES-1:0]    n_greater;
    logic [LANES-1:0]    n_equal;
    logic [LANES-1:0]    n_held;
    logic [LANES-1:0]    base_less;
    logic [LANES-1:0]    base_greater;
    logic [LANES-1:0]    base_equal;
    logic [LANES-1:0]    pred;
    logic [LANES-1:0]    combined;
    logic [LANES-1:0]    lane_mask;
    logic [ACTIVE_W-1:0] lanes_c;
    logic [LANES-1:0]    result;

    logic [LANES-1:0]    r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wr;
    logic [OQ_PTR_W-1:0] r_oq_rd;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    logic                pop_fire;
    logic                oq_push;

    // A new code starts from cleared less and greater masks and a full equal mask, and takes its prior word.
    assign base_less    = i_head.is_first ? '0 : r_less;
    assign base_greater = i_head.is_first ? '0 : r_greater;
    assign base_equal   = i_head.is_first ? '1 : r_equal;
    assign n_held       = i_head.is_first ? i_head.prior : r_held;

    // Refine the masks with the current plane, most significant first.
    assign n_less    = base_less | (base_equal & ~i_head.col & i_head.opnd);
    assign n_greater = base_greater | (base_equal & i_head.col & ~i_head.opnd);
    assign n_equal   = base_equal & ~(i_head.col ^ i_head.opnd);

    // Comparator on the final masks.
    always_comb begin
        case (i_head.cmp)
            CMP_LESS:          pred = n_less;
            CMP_GREATER:       pred = n_greater;
            CMP_LESS_EQUAL:    pred = n_less | n_equal;
            CMP_GREATER_EQUAL: pred = n_greater | n_equal;
            CMP_EQUAL:         pred = n_equal;
            CMP_NOT_EQUAL:     pred = ~n_equal;
            default:           pred = '0;
        endcase
    end

    // Combine with the prior bit vector word; unused code acts as set.
    always_comb begin
        case (i_head.comb)
            COMB_AND: combined = pred & n_held;
            COMB_OR:  combined = pred | n_held;
            default:  combined = pred;
        endcase
    end

    // Clear lanes at and above the active count.
    assign lanes_c = (i_head.lanes > ACTIVE_W'(LANES)) ? ACTIVE_W'(LANES) : i_head.lanes;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_mask[i] = (ACTIVE_W'(i) < lanes_c);
        end
    end

    assign result = combined & lane_mask;

    // Take the head unless it closes a code and the result queue has no room.
    assign pop_fire = i_pop && (r_oq_cnt != '0);
    assign o_deq    = i_head_valid
                      && (!i_head.is_last || (r_oq_cnt != OQ_CNT_W'(OQ_DEPTH)) || pop_fire);
    assign oq_push  = o_deq && i_head.is_last;

    // Mask state.
    always_ff @(posedge i_clk) begin
        if (o_deq) begin
            r_less    <= n_less;
            r_greater <= n_greater;
            r_equal   <= n_equal;
            r_held    <= n_held;
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wr] <= result;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr <= (r_oq_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                : r_oq_wr + OQ_PTR_W'(1);
            end
            if (pop_fire) begin
                r_oq_rd <= (r_oq_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                : r_oq_rd + OQ_PTR_W'(1);
            end
            if (oq_push && !pop_fire) begin
                r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(1);
            end else if (pop_fire && !oq_push) begin
                r_oq_cnt <= r_oq_cnt - OQ_CNT_W'(1);
            end
        end
    end

    assign o_empty       = (r_oq_cnt == '0);
    assign o_result_bits = r_oq[r_oq_rd];

endmodule

### sv/sliced_column_predicate_scan.sv
// Top level of the bit-sliced column predicate scan.
// One request carries one bit plane of 64 tuple codes, most significant plane
// first; a group of code_width planes yields one result word, pushed on its
// final plane. A request is taken every cycle while full is low; the front
// stage selects the literal bit or other column and tags the first and last
// plane, a two-entry work queue decouples it from the back stage, and the back
// stage refines the per-lane masks at one plane per cycle unless a final plane
// meets a full result queue that is not popped; a two-entry result queue keeps
// planes flowing while a result waits to be popped. Configuration writes are
// always ready and should be made only while no scan is in flight; comparator
// and combine setting are captured per plane.
module sliced_column_predicate_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [scps_pkg::LANES-1:0]      i_column_plane,
    input  logic [scps_pkg::LANES-1:0]      i_other_plane,
    input  logic [scps_pkg::LANES-1:0]      i_prior_bits,
    input  logic [scps_pkg::ACTIVE_W-1:0]   i_active_lanes,
    output logic                            empty,
    input  logic                            pop,
    output logic [scps_pkg::LANES-1:0]      o_result_bits,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scps_pkg::*;

    t_work    w_work;
    t_work    w_head;
    t_wq_stat w_wq_stat;
    logic     w_accept;
    logic     w_deq;

    assign full     = w_wq_stat.full;
    assign w_accept = push && !w_wq_stat.full;

    // Front stage.
    scps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_column_plane (i_column_plane),
        .i_other_plane  (i_other_plane),
        .i_prior_bits   (i_prior_bits),
        .i_active_lanes (i_active_lanes),
        .o_work         (w_work)
    );

    // Work queue.
    scps_work_q u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_work  (w_work),
        .i_deq   (w_deq),
        .o_head  (w_head),
        .o_stat  (w_wq_stat)
    );

    // Back stage.
    scps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_wq_stat.head_valid),
        .o_deq         (w_deq),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result_bits (o_result_bits)
    );

    // The work queue never holds more entries than it has.
    a_wq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wq_stat.count <= WQ_CNT_W'(WQ_DEPTH))
        else $error("work queue count out of range");

    // An accepted request is in the work queue on the next cycle.
    a_wq_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_wq_stat.count != '0))
        else $error("accepted request missing from work queue");

    // No result can appear without a queued plane to produce it.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_wq_stat.count == '0) && empty) |=> empty)
        else $error("result appeared with no work queued");

endmodule

### sim/testbench.sv
// Self-checking testbench for the bit-sliced column predicate scan.
`timescale 1ns / 1ps

module testbench;
    import scps_pkg::*;

    // Codes the package leaves unnamed, used to reach the fallback behavior.
    localparam logic [CMP_W-1:0]     CMP_UNKNOWN_HI = 3'd7;
    localparam logic [COMB_W-1:0]    COMB_UNKNOWN   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI  = 3'd7;

    localparam int PLANE_TARGET = 1100;
    localparam int WORD_TARGET  = 48;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // One plane request as it is driven onto the input ports.
    typedef struct {
        logic [LANES-1:0]    col;
        logic [LANES-1:0]    other;
        logic [LANES-1:0]    prior;
        logic [ACTIVE_W-1:0] lanes;
    } t_plane_req;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  push           = 1'b0;
    logic                  full;
    logic [LANES-1:0]      i_column_plane = '0;
    logic [LANES-1:0]      i_other_plane  = '0;
    logic [LANES-1:0]      i_prior_bits   = '0;
    logic [ACTIVE_W-1:0]   i_active_lanes = '0;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic [LANES-1:0]      o_result_bits;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    sliced_column_predicate_scan dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_column_plane (i_column_plane),
        .i_other_plane  (i_other_plane),
        .i_prior_bits   (i_prior_bits),
        .i_active_lanes (i_active_lanes),
        .empty          (empty),
        .pop            (pop),
        .o_result_bits  (o_result_bits),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration registers.
    logic [CMP_W-1:0]  cfg_cmp   = CMP_LESS;
    logic [COMB_W-1:0] cfg_comb  = COMB_SET;
    logic [LIT_W-1:0]  cfg_lit   = '0;
    logic              cfg_use   = 1'b0;
    logic [CW_W-1:0]   cfg_width = CODE_WIDTH_RESET;

    // Per-lane comparison state of the scan in progress.
    logic [LANES-1:0] lt_mask    = '0;
    logic [LANES-1:0] gt_mask    = '0;
    logic [LANES-1:0] eq_mask    = '1;
    logic [LANES-1:0] prior_hold = '0;
    int               plane_idx  = 0;

    t_plane_req       plane_backlog[$];
    logic [LANES-1:0] predicted_words[$];
    int               words_predicted = 0;
    int               planes_queued   = 0;
    int               planes_taken    = 0;
    int               mismatches      = 0;

    // Refines the lane masks with one plane and predicts the result word on the last one.
    task automatic scan_plane(input t_plane_req r);
        int               w;
        bit               last;
        int               bit_idx;
        int               n;
        logic [LANES-1:0] b;
        logic [LANES-1:0] y;
        w = (cfg_width == 0) ? 1 :
            ((cfg_width > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(cfg_width));
        last = (plane_idx + 1 >= w);
        if (plane_idx == 0) begin
            lt_mask    = '0;
            gt_mask    = '0;
            eq_mask    = '1;
            prior_hold = r.prior;
        end
        // The literal bit follows the plane, except that the last plane always uses bit 0.
        if (cfg_use) begin
            b = r.other;
        end else begin
            bit_idx = last ? 0 : (w - 1 - plane_idx);
            b = {LANES{cfg_lit[bit_idx]}};
        end
        lt_mask = lt_mask | (eq_mask & ~r.col & b);
        gt_mask = gt_mask | (eq_mask & r.col & ~b);
        eq_mask = eq_mask & ~(r.col ^ b);
        if (!last) begin
            plane_idx = plane_idx + 1;
        end else begin
            case (cfg_cmp)
                CMP_LESS:          y = lt_mask;
                CMP_GREATER:       y = gt_mask;
                CMP_LESS_EQUAL:    y = lt_mask | eq_mask;
                CMP_GREATER_EQUAL: y = gt_mask | eq_mask;
                CMP_EQUAL:         y = eq_mask;
                CMP_NOT_EQUAL:     y = ~eq_mask;
                default:           y = '0;
            endcase
            case (cfg_comb)
                COMB_AND: y = y & prior_hold;
                COMB_OR:  y = y | prior_hold;
                default:  ;
            endcase
            n = r.lanes;
            if (n > LANES) n = LANES;
            y = y & ~({LANES{1'b1}} << n);
            predicted_words.push_back(y);
            words_predicted++;
            plane_idx = 0;
        end
    endtask

    // Writes one register and keeps the valid high for a following write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COMPARISON: cfg_cmp   = data[CMP_W-1:0];
            CFG_COMBINE_OP: cfg_comb  = data[COMB_W-1:0];
            CFG_LITERAL:    cfg_lit   = data[LIT_W-1:0];
            CFG_USE_OTHER:  cfg_use   = data[0];
            CFG_CODE_WIDTH: cfg_width = data[CW_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] cmp, input logic [31:0] comb,
                              input logic [31:0] lit, input logic [31:0] use_other,
                              input logic [31:0] width);
        cfg_write(CFG_COMPARISON, cmp);
        cfg_write(CFG_COMBINE_OP, comb);
        cfg_write(CFG_LITERAL, lit);
        cfg_write(CFG_USE_OTHER, use_other);
        cfg_write(CFG_CODE_WIDTH, width);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_plane(input logic [LANES-1:0] col, input logic [LANES-1:0] other,
                             input logic [LANES-1:0] prior, input logic [ACTIVE_W-1:0] lanes);
        t_plane_req r;
        r.col   = col;
        r.other = other;
        r.prior = prior;
        r.lanes = lanes;
        plane_backlog.push_back(r);
        planes_queued++;
    endtask

    // Waits until every request is taken and every result word has come, then lets the pipe settle.
    task automatic wait_idle();
        while (planes_taken != planes_queued || predicted_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [LANES-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Few set bits, so that many lanes stay equal deep into the code.
    function automatic logic [LANES-1:0] sparse_word();
        return rand_word() & rand_word() & rand_word();
    endfunction

    function automatic logic [LANES-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [ACTIVE_W-1:0] pick_lanes();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ACTIVE_W'($urandom_range(LANES + 1, 127));
            2:       return ACTIVE_W'(LANES);
            default: return ACTIVE_W'($urandom_range(1, LANES));
        endcase
    endfunction

    // Sometimes sets the unused upper bits of a register write.
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        if ($urandom_range(0, 3) == 0) return value | ($urandom << width);
        return value;
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4, 5, 6, 7: return $urandom_range(1, 4);
            default:    return $urandom_range(5, 25);
        endcase
    endfunction

    // Plane driver: sends requests in bursts with gaps between them.
    t_plane_req cur_req;
    int         gap_left   = 0;
    int         burst_left = 0;

    always @(posedge i_clk) begin
        t_plane_req nxt;
        logic       go;
        if (push && !full) begin
            scan_plane(cur_req);
            planes_taken++;
        end
        if (!(push && full)) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (plane_backlog.size() > 0) begin
                nxt = plane_backlog.pop_front();
                go  = 1'b1;
                if (burst_left <= 1) begin
                    gap_left   = pick_gap();
                    burst_left = $urandom_range(1, 40);
                end else begin
                    burst_left--;
                end
            end
            push <= go;
            if (go) begin
                cur_req = nxt;
                i_column_plane <= nxt.col;
                i_other_plane  <= nxt.other;
                i_prior_bits   <= nxt.prior;
                i_active_lanes <= nxt.lanes;
            end
        end
    end

    // Result monitor: checks each popped word and stalls on a changing pattern.
    int stall_mode   = 0;
    int pattern_left = 0;
    int tick         = 0;

    always @(posedge i_clk) begin
        logic [LANES-1:0] want;
        logic             nxt;
        if (pop && !empty) begin
            if (predicted_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word %h", o_result_bits);
            end else begin
                want = predicted_words.pop_front();
                if (want !== o_result_bits) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result_bits mismatch: expected %h, got %h",
                                 want, o_result_bits);
                end
            end
        end
        if (pattern_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            pattern_left = $urandom_range(50, 300);
        end else begin
            pattern_left--;
        end
        tick++;
        case (stall_mode)
            0:       nxt = 1'b1;
            1:       nxt = 1'($urandom_range(0, 1));
            2:       nxt = ($urandom_range(0, 9) == 0);
            default: nxt = ((tick % 8) < 6);
        endcase
        pop <= nxt;
    end

    // Stimulus: directed corner cases, then random phases with a fresh setting each.
    initial begin
        logic [LANES-1:0] corner_words[4];
        int               corner_lanes[8];
        logic [31:0]      lit;
        logic [31:0]      cmp;
        logic             use_other;
        logic             lit_bit;
        int               w_raw;
        int               w_eff;
        int               groups;
        int               extra;
        logic [LANES-1:0] col;
        logic [LANES-1:0] noise;

        corner_words = '{'0, '1, {32{2'b01}}, rand_word()};
        corner_lanes = '{LANES, 1, 0, 127, LANES - 1, LANES + 1, 32, LANES};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every comparator and combine code on single-plane codes.
        cfg_write(CFG_UNUSED_LO, '1);
        for (int c = CMP_LESS; c <= CMP_UNKNOWN_HI; c++) begin
            set_config(c, c % (COMB_UNKNOWN + 1), (c % 2) ? '1 : '0, (c % 2) == 0, 1);
            add_plane(corner_words[c % 4], corner_words[(c + 1) % 4],
                      corner_words[(c + 2) % 4], ACTIVE_W'(corner_lanes[c]));
            wait_idle();
        end

        // A code width of zero behaves as one plane.
        set_config(CMP_EQUAL, COMB_OR, '1, 0, 0);
        add_plane(rand_word(), rand_word(), rand_word(), ACTIVE_W'(LANES));
        wait_idle();

        // Literal compare over three planes; the last plane uses literal bit 0.
        set_config(CMP_GREATER_EQUAL, COMB_AND, 32'hFFFF_FFFA, 0, 3);
        add_plane({LANES{1'b0}} ^ sparse_word(), rand_word(), '1, ACTIVE_W'(LANES));
        add_plane({LANES{1'b1}} ^ sparse_word(), rand_word(), rand_word(), ACTIVE_W'(LANES));
        add_plane({LANES{1'b0}} ^ sparse_word(), rand_word(), rand_word(), ACTIVE_W'(LANES));
        wait_idle();

        // Width lowered in the middle of a code: the next plane closes the scan.
        set_config(CMP_LESS_EQUAL, COMB_SET, '0, 1, 4);
        for (int p = 0; p < 2; p++) begin
            col = rand_word();
            add_plane(col, col ^ sparse_word(), rand_word(), ACTIVE_W'(LANES));
        end
        wait_idle();
        set_config(CMP_LESS_EQUAL, COMB_SET, '0, 1, 2);
        col = rand_word();
        add_plane(col, col ^ sparse_word(), rand_word(), ACTIVE_W'(LANES - 1));
        wait_idle();

        // Random phases: mostly whole codes with near-equal operands.
        while (planes_queued < PLANE_TARGET || words_predicted < WORD_TARGET) begin
            cmp = $urandom_range(0, 13);
            if (cmp > CMP_NOT_EQUAL) cmp = (cmp >= 12) ? cmp - 6 : cmp % (CMP_NOT_EQUAL + 1);
            case ($urandom_range(0, 5))
                0:       lit = '0;
                1:       lit = '1;
                default: lit = $urandom;
            endcase
            use_other = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0:          w_raw = 0;
                1:          w_raw = $urandom_range(MAX_CODE_BITS + 1, 63);
                2, 3:       w_raw = MAX_CODE_BITS;
                4, 5, 6, 7: w_raw = $urandom_range(9, MAX_CODE_BITS - 1);
                default:    w_raw = $urandom_range(1, 8);
            endcase
            w_eff = (w_raw == 0) ? 1 : ((w_raw > MAX_CODE_BITS) ? MAX_CODE_BITS : w_raw);
            groups = (w_eff > 8) ? $urandom_range(1, 2) : $urandom_range(1, 10);

            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), $urandom);
            set_config(with_junk(cmp, CMP_W), with_junk($urandom_range(0, COMB_UNKNOWN), COMB_W),
                       lit, with_junk(use_other, 1), with_junk(w_raw, CW_W));

            for (int g = 0; g < groups; g++) begin
                for (int p = 0; p < w_eff; p++) begin
                    noise   = ($urandom_range(0, 3) == 0) ? rand_word() : sparse_word();
                    lit_bit = (p == w_eff - 1) ? lit[0] : lit[w_eff - 1 - p];
                    col     = use_other ? rand_word() : ({LANES{lit_bit}} ^ noise);
                    add_plane(col, col ^ noise, pick_word(), pick_lanes());
                end
            end
            // Now and then leave a code unfinished for the next setting to pick up.
            if (w_eff > 1 && $urandom_range(0, 5) == 0) begin
                extra = $urandom_range(1, w_eff - 1);
                for (int p = 0; p < extra; p++)
                    add_plane(rand_word(), rand_word(), pick_word(), pick_lanes());
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && predicted_words.size() == 0) begin
            $display("[sliced_column_predicate_scan] OK");
        end else begin
            $display("[sliced_column_predicate_scan] ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4_000_000;
        $display("[sliced_column_predicate_scan] ERROR");
        $finish;
    end

endmodule

### sim.f
sv/scps_pkg.sv
sv/scps_front.sv
sv/scps_work_q.sv
sv/scps_back.sv
sv/sliced_column_predicate_scan.sv
sim/testbench.sv
